>>> hw/rtl/lkv_pkg.sv
package lkv_pkg;

  // default sizes
  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 16;

  // capacity register
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // one request
  typedef struct packed {
    logic               func;
    logic        [15:0] key;
    logic signed [15:0] temperature_in;
    logic        [13:0] humidity_in;
  } lkv_req_t;

  // one result
  typedef struct packed {
    logic               hit;
    logic signed [15:0] temperature_out;
    logic        [13:0] humidity_out;
  } lkv_rsp_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic commit;
    logic take_match;
    logic take_lru;
    logic take_free;
    logic write_key;
    logic write_data;
  } lkv_cmd_t;

  // per-cell status flags
  typedef struct packed {
    logic valid;
    logic match;
    logic lru;
    logic free_first;
  } lkv_stat_t;

endpackage

>>> hw/rtl/lkv_cell.sv
module lkv_cell #(
  parameter int unsigned ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic signed [15:0]           temperature_i,
  input  logic [13:0]                  humidity_i,
  input  logic [$clog2(ENTRIES+1)-1:0] lru_rank_i,
  input  logic [$clog2(ENTRIES+1)-1:0] sel_rank_i,
  input  lkv_pkg::lkv_cmd_t            cmd_i,
  input  logic                         free_i,
  output logic                         free_o,
  output lkv_pkg::lkv_stat_t           stat_o,
  output logic [$clog2(ENTRIES)-1:0]   rank_o,
  output logic signed [15:0]           temperature_o,
  output logic [13:0]                  humidity_o
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES+1);

  logic                valid_q;
  logic [KEY_BITS-1:0] key_q;
  logic signed [15:0]  temp_q;
  logic [13:0]         hum_q;
  logic [RW-1:0]       rank_q;
  logic                sel;
  logic                older;

  // status toward the controller
  assign stat_o.valid      = valid_q;
  assign stat_o.match      = valid_q && (key_q == key_i);
  assign stat_o.lru        = valid_q && (CW'(rank_q) == lru_rank_i);
  assign stat_o.free_first = !valid_q && free_i;

  // first-free token ripples down the row
  assign free_o = free_i && valid_q;

  // this cell is the target of the request
  assign sel = (cmd_i.take_match && stat_o.match) ||
               (cmd_i.take_lru   && stat_o.lru)   ||
               (cmd_i.take_free  && stat_o.free_first);

  // more recent than the promoted entry
  assign older = valid_q && (CW'(rank_q) < sel_rank_i);

  assign rank_o        = rank_q;
  assign temperature_o = temp_q;
  assign humidity_o    = hum_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.commit && sel) begin
      valid_q <= 1'b1;
    end
  end

  // entry payload and recency rank
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (sel) begin
        rank_q <= '0;
        if (cmd_i.write_key) begin
          key_q <= key_i;
        end
        if (cmd_i.write_data) begin
          temp_q <= temperature_i;
          hum_q  <= humidity_i;
        end
      end else if (older) begin
        rank_q <= rank_q + RW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// an accepted request is registered, and its result is loaded into the result register by the update pass in S_EVAL
// a new request is taken only in S_IDLE, after the compare-and-update pass over the cell row
// a waiting result stalls the update pass, not the acceptance of the next request
// reset: all entries invalid, occupancy zero, capacity 16, no result pending
// no clearing pass after reset
module lru_key_value_cache #(
  parameter int unsigned ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lkv_pkg::lkv_req_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lkv_pkg::lkv_rsp_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES+1);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  state_e                    state_q;
  lkv_pkg::lkv_req_t         req_q;
  lkv_pkg::lkv_rsp_t         rsp_q;
  logic                      out_valid_q;
  logic [CW-1:0]             occ_q;
  logic [lkv_pkg::CAP_W-1:0] cap_q;

  logic [31:0]               key_ext;
  logic [KEY_BITS-1:0]       key_m;
  logic [CW-1:0]             cap_eff;
  logic [CW-1:0]             lru_rank;
  logic [CW-1:0]             sel_rank;
  logic                      hit;
  logic                      is_put;
  logic                      evict;
  logic                      go;
  logic                      in_acc;
  logic                      out_acc;
  lkv_pkg::lkv_cmd_t         cmd;

  lkv_pkg::lkv_stat_t        stat   [ENTRIES];
  logic [RW-1:0]             rank   [ENTRIES];
  logic signed [15:0]        temp   [ENTRIES];
  logic [13:0]               hum    [ENTRIES];
  logic [ENTRIES:0]          free_chain;
  logic [ENTRIES-1:0]        valid_vec;
  logic [ENTRIES-1:0]        match_vec;
  logic [ENTRIES-1:0]        lru_vec;

  logic [RW-1:0]             match_rank;
  logic signed [15:0]        match_temp;
  logic [13:0]               match_hum;

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // key compared on its low bits only
  assign key_ext = 32'(req_q.key);
  assign key_m   = key_ext[KEY_BITS-1:0];

  // capacity clamped to the range 1 to the row size
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  // gather flags and hit data from the row
  always_comb begin
    match_rank = '0;
    match_temp = '0;
    match_hum  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = stat[i].valid;
      match_vec[i] = stat[i].match;
      lru_vec[i]   = stat[i].lru;
      if (stat[i].match) begin
        match_rank = match_rank | rank[i];
        match_temp = match_temp | temp[i];
        match_hum  = match_hum  | hum[i];
      end
    end
  end

  // request decode
  assign hit      = |match_vec;
  assign is_put   = (req_q.func == lkv_pkg::FUNC_PUT);
  assign evict    = (occ_q >= cap_eff);
  assign go       = (state_q == S_EVAL) && !(out_valid_q && out_stall_i);
  assign lru_rank = occ_q - CW'(1);

  // rank of the entry being promoted; a new entry enters below all others
  always_comb begin
    priority if (hit) begin
      sel_rank = CW'(match_rank);
    end else if (evict) begin
      sel_rank = lru_rank;
    end else begin
      sel_rank = occ_q;
    end
  end

  // command broadcast to the cells
  always_comb begin
    cmd.commit     = go && (hit || is_put);
    cmd.take_match = hit;
    cmd.take_lru   = !hit && is_put && evict;
    cmd.take_free  = !hit && is_put && !evict;
    cmd.write_key  = is_put && !hit;
    cmd.write_data = is_put;
  end

  // row of cells
  assign free_chain[0] = 1'b1;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .key_i         (key_m),
      .temperature_i (req_q.temperature_in),
      .humidity_i    (req_q.humidity_in),
      .lru_rank_i    (lru_rank),
      .sel_rank_i    (sel_rank),
      .cmd_i         (cmd),
      .free_i        (free_chain[g]),
      .free_o        (free_chain[g+1]),
      .stat_o        (stat[g]),
      .rank_o        (rank[g]),
      .temperature_o (temp[g]),
      .humidity_o    (hum[g])
    );
  end

  // controller state, occupancy, config and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
      cap_q       <= lkv_pkg::CAP_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (go) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            if (cmd.take_free) begin
              occ_q <= occ_q + CW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (go) begin
      rsp_q.hit <= hit;
      if (hit && !is_put) begin
        rsp_q.temperature_out <= match_temp;
        rsp_q.humidity_out    <= match_hum;
      end else begin
        rsp_q.temperature_out <= '0;
        rsp_q.humidity_out    <= '0;
      end
    end
  end

  // occupancy tracks the valid cells
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(valid_vec)) == 32'(occ_q))
    else $error("occupancy count differs from valid cell count");

  // keys are unique among valid entries
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> $onehot0(match_vec))
    else $error("more than one cell matches the key");

  // an eviction always finds exactly one least recent entry
  a_lru_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && cmd.take_lru) |-> $onehot(lru_vec))
    else $error("no unique least recent entry on eviction");

  // an allocation always finds a free cell
  a_free_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && cmd.take_free) |-> !free_chain[ENTRIES])
    else $error("allocation without a free cell");

  // every accepted request yields a result at its update pass
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_q && (state_q == S_IDLE))
    else $error("update pass did not load a result");

endmodule
